### src/swec_pkg.sv
// Shared types and constants for the split window edge classifier.
// Used by the column cell, line store, classifier pipeline and top level.
// Depends on nothing else.
package swec_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_SIZE       = 5;
    localparam int WIN_SIZE       = 5;
    localparam int STORED_ROWS    = 4;

    localparam logic [10:0] WIDTH_RESET    = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET   = 11'd1024;
    localparam logic [19:0] VAR_THR_RESET  = 20'd70;
    localparam logic [7:0]  MEAN_THR_RESET = 8'd20;

    localparam logic [7:0] MARK_LR   = 8'd255;
    localparam logic [7:0] MARK_TB   = 8'd127;
    localparam logic [7:0] MARK_NONE = 8'd0;

    // floor(s / 10) == (s * 3277) >> 15 for every half window sum up to 2550.
    localparam logic [11:0] RECIP_TEN   = 12'd3277;
    localparam int          RECIP_SHIFT = 15;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_VARIANCE_THRESHOLD,
        REG_MEAN_THRESHOLD
    } cfg_reg_t;

    // One window column, top row first, with the square of every pixel.
    typedef struct packed {
        logic [4:0][7:0]  px;
        logic [4:0][15:0] sq;
    } column_t;

    // Partial sums of one column: top two rows, middle row, bottom two rows.
    typedef struct packed {
        logic [8:0]  top_s;
        logic [7:0]  mid_s;
        logic [8:0]  bot_s;
        logic [16:0] top_q;
        logic [15:0] mid_q;
        logic [16:0] bot_q;
    } col_stats_t;

    typedef struct packed {
        logic       last;
        logic [9:0] center_column;
        logic [9:0] center_row;
    } meta_t;

endpackage

### src/swec_cell.sv
// One column cell of the 5x5 window chain.
// Holds a column of pixels and squares, hands it to its left neighbor on a shift.
// Depends on swec_pkg.
module swec_cell
    import swec_pkg::*;
(
    input  logic       clk,
    input  logic       shift_en,
    input  column_t    col_in,
    output column_t    col_out,
    output col_stats_t stats
);

    column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    always_comb
    begin
        stats.top_s = {1'b0, col_reg.px[0]} + {1'b0, col_reg.px[1]};
        stats.mid_s = col_reg.px[2];
        stats.bot_s = {1'b0, col_reg.px[3]} + {1'b0, col_reg.px[4]};
        stats.top_q = {1'b0, col_reg.sq[0]} + {1'b0, col_reg.sq[1]};
        stats.mid_q = col_reg.sq[2];
        stats.bot_q = {1'b0, col_reg.sq[3]} + {1'b0, col_reg.sq[4]};
    end

endmodule

### src/swec_line_store.sv
// Four row banks of pixel storage, one bank per stored image row.
// All banks are read at the same column; one bank is written there.
// Depends on swec_pkg.
module swec_line_store
    import swec_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  logic [1:0]                    wr_row,
    input  logic [7:0]                    wdata,
    output logic [STORED_ROWS-1:0][7:0]   rd_data
);

    logic [STORED_ROWS-1:0][7:0] rd_reg;

    for (genvar b = 0; b < STORED_ROWS; b++)
    begin : g_bank
        logic [7:0] mem [MAX_WIDTH];

        // The read returns the old entry when the same bank is written.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_row == 2'(b))
                begin
                    mem[addr] <= wdata;
                end
                rd_reg[b] <= mem[addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

### src/swec_classify.sv
// Classifier pipeline: half window sums, means, squared means, threshold tests.
// Four registered stages with per-stage valid; bubbles collapse under stall.
// Depends on swec_pkg.
module swec_classify
    import swec_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  col_stats_t [WIN_SIZE-1:0]   stats,
    input  meta_t                       meta,
    input  logic [19:0]                 variance_threshold,
    input  logic [7:0]                  mean_threshold,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  mark,
    output logic [9:0]                  center_column,
    output logic [9:0]                  center_row,
    output logic                        last
);

    localparam int HL = 0;
    localparam int HR = 1;
    localparam int HT = 2;
    localparam int HB = 3;

    logic take_a, take_b, take_c, take_o;

    logic [4:0][10:0] col_s;
    logic [4:0][18:0] col_q;
    logic [3:0][11:0] a_sum_next;
    logic [3:0][19:0] a_sq_next;

    logic             a_valid_reg;
    logic [3:0][11:0] a_sum_reg;
    logic [3:0][19:0] a_sq_reg;
    meta_t            a_meta_reg;

    logic [3:0][23:0] b_prod;
    logic             b_valid_reg;
    logic [3:0][7:0]  b_mean_reg;
    logic [3:0][19:0] b_sq_reg;
    meta_t            b_meta_reg;

    logic [7:0]       diff_lr, diff_tb;
    logic             c_valid_reg;
    logic [3:0][15:0] c_msq_reg;
    logic [3:0][19:0] c_sq_reg;
    logic             c_mean_lr_reg, c_mean_tb_reg;
    meta_t            c_meta_reg;

    logic [3:0][19:0] spread;
    logic             pass_lr, pass_tb;
    logic [7:0]       mark_next;

    logic             out_valid_reg;
    logic [7:0]       mark_reg;
    meta_t            out_meta_reg;

    assign take_o   = !out_valid_reg || !out_stall;
    assign take_c   = !c_valid_reg || take_o;
    assign take_b   = !b_valid_reg || take_c;
    assign take_a   = !a_valid_reg || take_b;
    assign in_ready = take_a;

    // Stage A: add column partial sums into the four half windows.
    always_comb
    begin
        for (int k = 0; k < WIN_SIZE; k++)
        begin
            col_s[k] = 11'(stats[k].top_s) + 11'(stats[k].mid_s) + 11'(stats[k].bot_s);
            col_q[k] = 19'(stats[k].top_q) + 19'(stats[k].mid_q) + 19'(stats[k].bot_q);
        end
    end

    always_comb
    begin
        a_sum_next[HL] = 12'(col_s[0]) + 12'(col_s[1]);
        a_sum_next[HR] = 12'(col_s[3]) + 12'(col_s[4]);
        a_sq_next[HL]  = 20'(col_q[0]) + 20'(col_q[1]);
        a_sq_next[HR]  = 20'(col_q[3]) + 20'(col_q[4]);
        a_sum_next[HT] = '0;
        a_sum_next[HB] = '0;
        a_sq_next[HT]  = '0;
        a_sq_next[HB]  = '0;
        for (int k = 0; k < WIN_SIZE; k++)
        begin
            a_sum_next[HT] = a_sum_next[HT] + 12'(stats[k].top_s);
            a_sum_next[HB] = a_sum_next[HB] + 12'(stats[k].bot_s);
            a_sq_next[HT]  = a_sq_next[HT] + 20'(stats[k].top_q);
            a_sq_next[HB]  = a_sq_next[HB] + 20'(stats[k].bot_q);
        end
    end

    // Stage B: divide each sum by ten through a reciprocal multiply.
    always_comb
    begin
        for (int h = 0; h < 4; h++)
        begin
            b_prod[h] = 24'(a_sum_reg[h]) * 24'(RECIP_TEN);
        end
    end

    // Stage C: square the means and test the mean differences.
    assign diff_lr = (b_mean_reg[HL] > b_mean_reg[HR]) ? b_mean_reg[HL] - b_mean_reg[HR]
                                                         : b_mean_reg[HR] - b_mean_reg[HL];
    assign diff_tb = (b_mean_reg[HT] > b_mean_reg[HB]) ? b_mean_reg[HT] - b_mean_reg[HB]
                                                         : b_mean_reg[HB] - b_mean_reg[HT];

    // Output stage: the sum of squares is never below the squared mean,
    // so the spread needs no sign bit.
    always_comb
    begin
        for (int h = 0; h < 4; h++)
        begin
            spread[h] = c_sq_reg[h] - 20'(c_msq_reg[h]);
        end
        pass_lr = (spread[HL] > variance_threshold) && (spread[HR] > variance_threshold)
                  && c_mean_lr_reg;
        pass_tb = (spread[HT] > variance_threshold) && (spread[HB] > variance_threshold)
                  && c_mean_tb_reg;
        if (pass_lr)
        begin
            mark_next = MARK_LR;
        end
        else if (pass_tb)
        begin
            mark_next = MARK_TB;
        end
        else
        begin
            mark_next = MARK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (take_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (take_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (take_o)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_a && in_valid)
        begin
            a_sum_reg  <= a_sum_next;
            a_sq_reg   <= a_sq_next;
            a_meta_reg <= meta;
        end
        if (take_b && a_valid_reg)
        begin
            for (int h = 0; h < 4; h++)
            begin
                b_mean_reg[h] <= b_prod[h][RECIP_SHIFT +: 8];
            end
            b_sq_reg   <= a_sq_reg;
            b_meta_reg <= a_meta_reg;
        end
        if (take_c && b_valid_reg)
        begin
            for (int h = 0; h < 4; h++)
            begin
                c_msq_reg[h] <= 16'(b_mean_reg[h]) * 16'(b_mean_reg[h]);
            end
            c_sq_reg      <= b_sq_reg;
            c_mean_lr_reg <= diff_lr > mean_threshold;
            c_mean_tb_reg <= diff_tb > mean_threshold;
            c_meta_reg    <= b_meta_reg;
        end
        if (take_o && c_valid_reg)
        begin
            mark_reg     <= mark_next;
            out_meta_reg <= c_meta_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mark          = mark_reg;
    assign center_column = out_meta_reg.center_column;
    assign center_row    = out_meta_reg.center_row;
    assign last          = out_meta_reg.last;

endmodule

### src/split_window_edge_classifier_unit.sv
// Split window edge classifier: raster pixels in, one mark per interior pixel out.
// Uses swec_pkg, swec_line_store, swec_cell and swec_classify.
//
// Usage:
//   Pixels arrive on the in channel (in_valid, in_stall, pixel, frame_start) in
//   raster order; frame_start restarts the position at column 0, row 0. A request
//   is taken on a clock edge with in_valid high and in_stall low.
//   For every pixel at column x >= 4 and row y >= 4 the out channel (out_valid,
//   out_stall, mark, center_column, center_row, last) delivers the mark for
//   center (x-2, y-2): 255 for a left/right change, 127 for a top/bottom change,
//   0 otherwise. Border pixels give no output request.
//   The output request passes the input stage, the window stage and the classifier stages in turn.
//   Throughput: one pixel per clock while in_stall is low; for each taken pixel
//   all four row banks are read at its column and the bank for its row is written.
//   While out_stall is held, the block keeps taking pixels until the four
//   classifier stages, the window stage and the input stage all hold a request,
//   then raises in_stall; nothing is dropped.
//   Reset clears the position, the pipeline valids and the configuration
//   (width 1024, height 1024, variance threshold 70, mean threshold 20).
//   The row banks need no clearing pass: a frame fills them before use.
//   Configuration writes are accepted on any cycle with write_enable high.
module split_window_edge_classifier_unit
    import swec_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mark,
    output logic [9:0]  center_column,
    output logic [9:0]  center_row,
    output logic        last,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [19:0] write_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [10:0] image_width_reg, image_height_reg;
    logic [19:0] variance_threshold_reg;
    logic [7:0]  mean_threshold_reg;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] x_cur, width_last;
    logic [RW-1:0] y_cur, height_last;
    logic [12:0]   width_ext, height_ext;
    logic          at_row_end, at_frame_end, has_result;
    meta_t         meta_next;

    logic          accept;
    logic          take_s1, take_w, cls_ready;

    logic          s1_valid_reg, s1_result_reg;
    logic [7:0]    s1_pixel_reg;
    logic [1:0]    s1_row_sel_reg;
    meta_t         s1_meta_reg;

    logic [STORED_ROWS-1:0][7:0] line_q;
    column_t       new_col;
    logic          shift_en;

    logic          w_valid_reg, w_result_reg;
    meta_t         w_meta_reg;

    column_t [WIN_SIZE-1:0]    cell_in;
    column_t [WIN_SIZE-1:1]    cell_out;
    col_stats_t [WIN_SIZE-1:0] cell_stats;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg        <= WIDTH_RESET;
            image_height_reg       <= HEIGHT_RESET;
            variance_threshold_reg <= VAR_THR_RESET;
            mean_threshold_reg     <= MEAN_THR_RESET;
        end
        else if (write_enable)
        begin
            unique case (cfg_reg_t'(write_index))
                REG_IMAGE_WIDTH:        image_width_reg        <= write_data[10:0];
                REG_IMAGE_HEIGHT:       image_height_reg       <= write_data[10:0];
                REG_VARIANCE_THRESHOLD: variance_threshold_reg <= write_data;
                REG_MEAN_THRESHOLD:     mean_threshold_reg     <= write_data[7:0];
            endcase
        end
    end

    // Frame size clamped to the supported range, as last column and last row.
    assign width_ext  = {2'b00, image_width_reg};
    assign height_ext = {2'b00, image_height_reg};

    always_comb
    begin
        if (width_ext < 13'(MIN_SIZE))
        begin
            width_last = CW'(MIN_SIZE - 1);
        end
        else if (width_ext > 13'(MAX_WIDTH))
        begin
            width_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            width_last = CW'(width_ext - 13'd1);
        end
        if (height_ext < 13'(MIN_SIZE))
        begin
            height_last = RW'(MIN_SIZE - 1);
        end
        else if (height_ext > 13'(MAX_HEIGHT))
        begin
            height_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            height_last = RW'(height_ext - 13'd1);
        end
    end

    // Raster position of the incoming pixel and the position after it.
    assign x_cur        = frame_start ? '0 : column_count_reg;
    assign y_cur        = frame_start ? '0 : row_count_reg;
    assign at_row_end   = x_cur >= width_last;
    assign at_frame_end = y_cur >= height_last;
    assign has_result   = (x_cur >= CW'(WIN_SIZE - 1)) && (y_cur >= RW'(WIN_SIZE - 1));

    always_comb
    begin
        if (at_row_end)
        begin
            column_count_next = '0;
            row_count_next    = at_frame_end ? '0 : y_cur + RW'(1);
        end
        else
        begin
            column_count_next = x_cur + CW'(1);
            row_count_next    = y_cur;
        end
        meta_next.last          = at_row_end && at_frame_end;
        meta_next.center_column = 10'({10'd0, x_cur} - (CW + 10)'(2));
        meta_next.center_row    = 10'({10'd0, y_cur} - (RW + 10)'(2));
    end

    // Handshake chain: the window stage drops border items without waiting.
    assign take_w   = !w_valid_reg || !w_result_reg || cls_ready;
    assign take_s1  = !s1_valid_reg || take_w;
    assign in_stall = !take_s1;
    assign accept   = in_valid && take_s1;
    assign shift_en = s1_valid_reg && take_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            w_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
            end
            if (take_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (take_w)
            begin
                w_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pixel;
            s1_row_sel_reg <= y_cur[1:0];
            s1_result_reg  <= has_result;
            s1_meta_reg    <= meta_next;
        end
        if (shift_en)
        begin
            w_result_reg <= s1_result_reg;
            w_meta_reg   <= s1_meta_reg;
        end
    end

    swec_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .en      (accept),
        .addr    (x_cur),
        .wr_row  (y_cur[1:0]),
        .wdata   (pixel),
        .rd_data (line_q)
    );

    // The new right column: four stored rows, oldest first, then the pixel.
    always_comb
    begin
        for (int r = 0; r < STORED_ROWS; r++)
        begin
            new_col.px[r] = line_q[2'(s1_row_sel_reg + 2'(r))];
        end
        new_col.px[WIN_SIZE-1] = s1_pixel_reg;
        for (int r = 0; r < WIN_SIZE; r++)
        begin
            new_col.sq[r] = 16'(new_col.px[r]) * 16'(new_col.px[r]);
        end
    end

    for (genvar k = 0; k < WIN_SIZE; k++)
    begin : g_cell
        if (k == WIN_SIZE - 1)
        begin : g_entry
            assign cell_in[k] = new_col;
        end
        else
        begin : g_link
            assign cell_in[k] = cell_out[k+1];
        end

        if (k == 0)
        begin : g_oldest
            swec_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .col_in   (cell_in[k]),
                .col_out  (),
                .stats    (cell_stats[k])
            );
        end
        else
        begin : g_inner
            swec_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .col_in   (cell_in[k]),
                .col_out  (cell_out[k]),
                .stats    (cell_stats[k])
            );
        end
    end

    swec_classify u_classify (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (w_valid_reg && w_result_reg),
        .in_ready           (cls_ready),
        .stats              (cell_stats),
        .meta               (w_meta_reg),
        .variance_threshold (variance_threshold_reg),
        .mean_threshold     (mean_threshold_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .mark               (mark),
        .center_column      (center_column),
        .center_row         (center_row),
        .last               (last)
    );

`ifndef ASSERT_OFF
    a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty first stage");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !take_w |=> s1_valid_reg)
        else $error("first stage item lost while the window stage was blocked");

    a_frame_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_start |=> column_count_reg == CW'(1) && row_count_reg == '0)
        else $error("frame start did not restart the raster position");

    a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mark == MARK_LR || mark == MARK_TB || mark == MARK_NONE)
        else $error("output mark is not a defined code");
`endif

endmodule
